@@ sv/weighted_interpolation_upsampler_defines.svh @@
// assertion macros shared by the upsampler modules
// no dependencies; included by files that carry assertions
`ifndef WEIGHTED_INTERPOLATION_UPSAMPLER_DEFINES_SVH
`define WEIGHTED_INTERPOLATION_UPSAMPLER_DEFINES_SVH

// same-cycle implication, disabled in reset
`define WIU_ASSERT_IMPL(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("upsampler assertion failed");

// next-cycle implication, disabled in reset
`define WIU_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("upsampler assertion failed");

`endif

@@ sv/wiu_pkg.sv @@
// shared types and constants of the weighted interpolation upsampler
// no dependencies
package wiu_pkg;

    localparam int CFG_BITS     = 7;
    localparam int PHASE_BITS   = 6;
    // weights and their sum stay below 3 * 127
    localparam int WGT_BITS     = 9;
    localparam int MAX_FACTOR   = 64;
    localparam int FACTOR_RESET = 15;
    localparam int BAND_RESET   = 5;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        CFG_FACTOR = 1'b0,
        CFG_BAND   = 1'b1
    } t_cfg_reg;

    typedef struct packed {
        logic                first;
        logic [CFG_BITS-1:0] factor;
        logic [CFG_BITS-1:0] band;
    } t_seg_ctrl;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_WEIGHT,
        BK_MUL,
        BK_SUM,
        BK_DIV,
        BK_EMIT
    } t_back_state;

endpackage

@@ sv/wiu_front.sv @@
// front end: configuration registers, input acceptance, segment classification
// depends on wiu_pkg
module wiu_front
    import wiu_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [0:0]             i_cfg_idx,
    input  logic [CFG_BITS-1:0]    i_cfg_data,
    input  logic                   i_in_valid,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_q_full,
    output logic                   o_in_stall,
    output logic                   o_push,
    output t_seg_ctrl              o_ctrl,
    output logic [SAMPLE_BITS-1:0] o_prev,
    output logic [SAMPLE_BITS-1:0] o_cur
);

    localparam logic [CFG_BITS-1:0] FACTOR_CAP = CFG_BITS'(MAX_FACTOR);
    localparam logic [CFG_BITS-1:0] ONE        = CFG_BITS'(1);

    logic [CFG_BITS-1:0]    r_factor;
    logic [CFG_BITS-1:0]    r_band;
    logic [SAMPLE_BITS-1:0] r_prev;
    logic                   r_have_prev;
    logic [CFG_BITS-1:0]    factor_eff;
    logic                   accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= CFG_BITS'(FACTOR_RESET);
            r_band   <= CFG_BITS'(BAND_RESET);
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_FACTOR) begin
                r_factor <= i_cfg_data;
            end
            if (i_cfg_idx == CFG_BAND) begin
                r_band <= i_cfg_data;
            end
        end
    end

    // zero acts as one, anything above the cap acts as the cap
    always_comb begin
        priority if (r_factor == '0) begin
            factor_eff = ONE;
        end else if (r_factor > FACTOR_CAP) begin
            factor_eff = FACTOR_CAP;
        end else begin
            factor_eff = r_factor;
        end
    end

    assign o_in_stall = i_q_full;
    assign accept     = i_in_valid && !i_q_full;
    assign o_push     = accept;
    assign o_cur      = i_sample;
    assign o_prev     = r_prev;

    always_comb begin
        o_ctrl.first  = !r_have_prev;
        o_ctrl.factor = factor_eff;
        o_ctrl.band   = r_band;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev      <= '0;
            r_have_prev <= 1'b0;
        end else if (accept) begin
            r_prev      <= i_sample;
            r_have_prev <= 1'b1;
        end
    end

endmodule

@@ sv/wiu_queue.sv @@
// short segment queue between front and back end
// depends on wiu_pkg and the assertion macro header
`include "weighted_interpolation_upsampler_defines.svh"
module wiu_queue
    import wiu_pkg::*;
#(
    parameter int DATA_BITS = 40
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  logic [DATA_BITS-1:0] i_data,
    input  logic                 i_pop,
    output logic                 o_full,
    output logic                 o_empty,
    output logic [DATA_BITS-1:0] o_data
);

    logic [DATA_BITS-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr;
    logic [QPTR_BITS-1:0] r_rd;
    logic [QCNT_BITS-1:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_full  = (r_count == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    `WIU_ASSERT_IMPL(a_no_overflow, i_clk, i_rst_n, i_push, r_count < QCNT_BITS'(QUEUE_DEPTH))
    `WIU_ASSERT_IMPL(a_no_underflow, i_clk, i_rst_n, i_pop, r_count != '0)

endmodule

@@ sv/wiu_div.sv @@
// serial restoring divider, one quotient bit per cycle
// depends on wiu_pkg
module wiu_div
    import wiu_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_start,
    input  logic [SAMPLE_BITS+WGT_BITS-1:0] i_mag,
    input  logic [WGT_BITS-1:0]             i_den,
    output logic                            o_done,
    output logic [SAMPLE_BITS-1:0]          o_quot
);

    localparam int CNT_BITS = $clog2(SAMPLE_BITS + 1);

    logic [WGT_BITS-1:0]    r_rem;
    logic [SAMPLE_BITS-1:0] r_shift;
    logic [CNT_BITS-1:0]    r_cnt;
    logic                   r_busy;
    logic                   r_done;
    logic [WGT_BITS:0]      trial;
    logic [WGT_BITS:0]      diff;
    logic                   ge;

    assign trial = {r_rem, r_shift[SAMPLE_BITS-1]};
    assign ge    = (trial >= {1'b0, i_den});
    assign diff  = trial - {1'b0, i_den};

    // numerator bits above the quotient width start as the remainder,
    // which is below the divisor since the mean fits the sample range
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= i_mag[SAMPLE_BITS+WGT_BITS-1:SAMPLE_BITS];
            r_shift <= i_mag[SAMPLE_BITS-1:0];
        end else if (r_busy) begin
            r_rem   <= ge ? diff[WGT_BITS-1:0] : trial[WGT_BITS-1:0];
            r_shift <= {r_shift[SAMPLE_BITS-2:0], ge};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_cnt  <= CNT_BITS'(SAMPLE_BITS);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CNT_BITS'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_shift;

endmodule

@@ sv/wiu_back.sv @@
// back end: phase sequencer, weight and product datapath, divider, output register
// depends on wiu_pkg, wiu_div and the assertion macro header
`include "weighted_interpolation_upsampler_defines.svh"
module wiu_back
    import wiu_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_q_empty,
    input  t_seg_ctrl              i_ctrl,
    input  logic [SAMPLE_BITS-1:0] i_prev,
    input  logic [SAMPLE_BITS-1:0] i_cur,
    input  logic                   i_out_stall,
    output logic                   o_pop,
    output logic                   o_out_valid,
    output logic [SAMPLE_BITS-1:0] o_value,
    output logic [PHASE_BITS-1:0]  o_phase,
    output logic                   o_last
);

    localparam int PROD_BITS = SAMPLE_BITS + WGT_BITS + 1;
    localparam int SUM_BITS  = PROD_BITS + 1;
    localparam int MAG_BITS  = SAMPLE_BITS + WGT_BITS;

    t_back_state r_state;
    t_back_state n_state;

    logic [SAMPLE_BITS-1:0]     r_cur;
    logic [SAMPLE_BITS-1:0]     r_prev;
    logic [CFG_BITS-1:0]        r_len;
    logic [CFG_BITS-1:0]        r_band;
    logic [CFG_BITS-1:0]        r_k;
    logic [WGT_BITS-1:0]        r_wp;
    logic [WGT_BITS-1:0]        r_wc;
    logic [WGT_BITS-1:0]        r_den;
    logic signed [PROD_BITS-1:0] r_prod_p;
    logic signed [PROD_BITS-1:0] r_prod_c;
    logic                       r_neg;
    logic                       r_out_valid;
    logic [SAMPLE_BITS-1:0]     r_value;
    logic [PHASE_BITS-1:0]      r_phase;
    logic                       r_last;

    logic                       pop;
    logic                       div_start;
    logic                       emit;
    logic                       out_free;
    logic                       div_done;
    logic [SAMPLE_BITS-1:0]     quot;
    logic [SAMPLE_BITS-1:0]     point;
    logic [CFG_BITS-1:0]        k_inc;
    logic [CFG_BITS-1:0]        len_k;
    logic                       near_prev;
    logic                       near_cur;
    logic [WGT_BITS-1:0]        lk_w;
    logic [WGT_BITS-1:0]        k_w;
    logic [WGT_BITS-1:0]        wp;
    logic [WGT_BITS-1:0]        wc;
    logic signed [SUM_BITS-1:0] sum;
    logic [SUM_BITS-1:0]        sum_abs;

    assign out_free = !r_out_valid || !i_out_stall;
    assign k_inc    = r_k + 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (!i_q_empty) begin
                    n_state = (i_ctrl.first || i_ctrl.factor == CFG_BITS'(1)) ? BK_EMIT
                                                                              : BK_WEIGHT;
                end
            end
            BK_WEIGHT: n_state = BK_MUL;
            BK_MUL:    n_state = BK_SUM;
            BK_SUM:    n_state = BK_DIV;
            BK_DIV: begin
                if (div_done) begin
                    n_state = BK_EMIT;
                end
            end
            BK_EMIT: begin
                if (out_free) begin
                    priority if (r_k == '0) begin
                        n_state = BK_IDLE;
                    end else if (k_inc == r_len) begin
                        n_state = BK_EMIT;
                    end else begin
                        n_state = BK_WEIGHT;
                    end
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        pop       = 1'b0;
        div_start = 1'b0;
        emit      = 1'b0;
        unique case (r_state)
            BK_IDLE: pop       = !i_q_empty;
            BK_SUM:  div_start = 1'b1;
            BK_EMIT: emit      = out_free;
            default: begin
                pop       = 1'b0;
                div_start = 1'b0;
                emit      = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // weights: the previous sample's weight is tripled near it, the current one's near it
    assign len_k     = r_len - r_k;
    assign near_prev = (r_k < r_band);
    assign near_cur  = ({1'b0, r_k} + {1'b0, r_band}) > {1'b0, r_len};
    assign lk_w      = WGT_BITS'(len_k);
    assign k_w       = WGT_BITS'(r_k);

    always_comb begin
        priority if (near_prev) begin
            wp = lk_w + {lk_w[WGT_BITS-2:0], 1'b0};
            wc = k_w;
        end else if (near_cur) begin
            wp = lk_w;
            wc = k_w + {k_w[WGT_BITS-2:0], 1'b0};
        end else begin
            wp = lk_w;
            wc = k_w;
        end
    end

    assign sum     = SUM_BITS'(r_prod_p) + SUM_BITS'(r_prod_c);
    assign sum_abs = sum[SUM_BITS-1] ? SUM_BITS'(-sum) : SUM_BITS'(sum);

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cur  <= i_cur;
            r_prev <= i_prev;
            r_len  <= i_ctrl.factor;
            r_band <= i_ctrl.band;
        end
        if (r_state == BK_WEIGHT) begin
            r_wp  <= wp;
            r_wc  <= wc;
            r_den <= wp + wc;
        end
        if (r_state == BK_MUL) begin
            r_prod_p <= PROD_BITS'($signed({1'b0, r_wp}) * $signed(r_prev));
            r_prod_c <= PROD_BITS'($signed({1'b0, r_wc}) * $signed(r_cur));
        end
        if (r_state == BK_SUM) begin
            r_neg <= sum[SUM_BITS-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_k <= '0;
        end else if (pop) begin
            r_k <= (i_ctrl.first || i_ctrl.factor == CFG_BITS'(1)) ? '0 : CFG_BITS'(1);
        end else if (emit && r_k != '0) begin
            r_k <= (k_inc == r_len) ? '0 : k_inc;
        end
    end

    // the divider loads the magnitude of this point's sum as it starts
    wiu_div #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_mag  (sum_abs[MAG_BITS-1:0]),
        .i_den  (r_den),
        .o_done (div_done),
        .o_quot (quot)
    );

    // truncation toward zero: divide magnitudes, restore the sign
    assign point = r_neg ? SAMPLE_BITS'(-quot) : quot;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_value <= (r_k == '0) ? r_cur : point;
            r_phase <= r_k[PHASE_BITS-1:0];
            r_last  <= (r_k == '0);
        end
    end

    assign o_pop       = pop;
    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_phase     = r_phase;
    assign o_last      = r_last;

    `WIU_ASSERT_IMPL(a_div_done_in_div, i_clk, i_rst_n, div_done, r_state == BK_DIV)
    `WIU_ASSERT_IMPL(a_phase_in_range, i_clk, i_rst_n, r_state == BK_WEIGHT, (r_k != '0) && (r_k < r_len))
    `WIU_ASSERT_NEXT(a_sample_ends_seg, i_clk, i_rst_n, emit && (r_k == '0), r_state == BK_IDLE)

endmodule

@@ sv/weighted_interpolation_upsampler.sv @@
// top level of the weighted interpolation upsampler
// depends on wiu_pkg, wiu_front, wiu_queue and wiu_back
//
// Upsamples a stream of signed samples by the factor L held in register 0
// (upsample_factor; 0 acts as 1, values above 64 act as 64). The first
// sample after reset comes out alone at phase 0. Every later sample c first
// yields L-1 points at phases 1..L-1 between the previous sample p and c,
// then c itself at phase 0 with last set. A point at phase k is
// (wp*p + wc*c)/(wp + wc) truncated toward zero, with weights (3(L-k), k)
// when k is below edge_band (register 1), (L-k, 3k) when k is above
// L - edge_band, and (L-k, k) otherwise. The front end takes an input
// transaction whenever the two-entry segment queue has room, so inputs
// keep flowing while results wait on the output stall. The back end works
// one segment at a time; each interpolated point passes through weights,
// two products, sum, a one-bit-per-cycle divider and emit, while a
// pass-through sample goes straight to emit. Configuration writes take
// effect for samples accepted after the write and are meant only while
// the block is idle.
module weighted_interpolation_upsampler
    import wiu_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    // configuration write port
    input  logic                   i_cfg_we,
    input  logic [0:0]             i_cfg_idx,
    input  logic [CFG_BITS-1:0]    i_cfg_data,
    // input sample channel
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    // result channel
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic [SAMPLE_BITS-1:0] o_value,
    output logic [PHASE_BITS-1:0]  o_phase,
    output logic                   o_last
);

    // queue entry: segment control, previous sample, current sample
    localparam int ENTRY_BITS = $bits(t_seg_ctrl) + 2 * SAMPLE_BITS;

    logic                   push;
    logic                   pop;
    logic                   q_full;
    logic                   q_empty;
    t_seg_ctrl              f_ctrl;
    logic [SAMPLE_BITS-1:0] f_prev;
    logic [SAMPLE_BITS-1:0] f_cur;
    logic [ENTRY_BITS-1:0]  q_wdata;
    logic [ENTRY_BITS-1:0]  q_rdata;
    t_seg_ctrl              b_ctrl;
    logic [SAMPLE_BITS-1:0] b_prev;
    logic [SAMPLE_BITS-1:0] b_cur;

    // front end: config registers, sample history, first-sample classification
    wiu_front #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg_we  (i_cfg_we),
        .i_cfg_idx (i_cfg_idx),
        .i_cfg_data(i_cfg_data),
        .i_in_valid(i_in_valid),
        .i_sample  (i_sample),
        .i_q_full  (q_full),
        .o_in_stall(o_in_stall),
        .o_push    (push),
        .o_ctrl    (f_ctrl),
        .o_prev    (f_prev),
        .o_cur     (f_cur)
    );

    assign q_wdata = {f_ctrl, f_prev, f_cur};

    // decouples input acceptance from segment processing
    wiu_queue #(
        .DATA_BITS(ENTRY_BITS)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_data (q_wdata),
        .i_pop  (pop),
        .o_full (q_full),
        .o_empty(q_empty),
        .o_data (q_rdata)
    );

    assign b_ctrl = t_seg_ctrl'(q_rdata[ENTRY_BITS-1:2*SAMPLE_BITS]);
    assign b_prev = q_rdata[2*SAMPLE_BITS-1:SAMPLE_BITS];
    assign b_cur  = q_rdata[SAMPLE_BITS-1:0];

    // back end: per-phase weighting, division and the output register
    wiu_back #(
        .SAMPLE_BITS(SAMPLE_BITS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_empty  (q_empty),
        .i_ctrl     (b_ctrl),
        .i_prev     (b_prev),
        .i_cur      (b_cur),
        .i_out_stall(i_out_stall),
        .o_pop      (pop),
        .o_out_valid(o_out_valid),
        .o_value    (o_value),
        .o_phase    (o_phase),
        .o_last     (o_last)
    );

endmodule

@@ bench/upsample_checker.sv @@
// checker for the weighted interpolation upsampler: predicts and compares results
// depends on wiu_pkg; watches the config port and both transaction channels
module upsample_checker
    import wiu_pkg::*;
#(
    parameter int SAMPLE_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic [0:0]             i_cfg_idx,
    input  logic [CFG_BITS-1:0]    i_cfg_data,
    input  logic                   i_in_valid,
    input  logic                   i_in_stall,
    input  logic [SAMPLE_BITS-1:0] i_sample,
    input  logic                   i_out_valid,
    input  logic                   i_out_stall,
    input  logic [SAMPLE_BITS-1:0] i_value,
    input  logic [PHASE_BITS-1:0]  i_phase,
    input  logic                   i_last,
    output int                     o_fails,
    output int                     o_pending
);

    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [SAMPLE_BITS-1:0] value;
        logic [PHASE_BITS-1:0]  phase;
        logic                   last;
    } t_point;

    t_point              pending_points[$];
    logic [CFG_BITS-1:0] factor_reg;
    logic [CFG_BITS-1:0] band_reg;
    longint              prev_sample;
    logic                have_prev;

    // queue every point that one accepted sample produces
    task automatic predict_segment(input logic [SAMPLE_BITS-1:0] raw);
        longint cur;
        longint len;
        longint band;
        longint k;
        longint wp;
        longint wc;
        longint mean;
        t_point pt;
        cur  = longint'($signed(raw));
        len  = longint'(factor_reg);
        band = longint'(band_reg);
        if (len < 1) len = 1;
        if (len > MAX_FACTOR) len = MAX_FACTOR;
        if (have_prev) begin
            for (k = 1; k < len; k++) begin
                // lower band first, so a wide band covers every phase
                if (k < band) begin
                    wp = 3 * (len - k);
                    wc = k;
                end else if (k > len - band) begin
                    wp = len - k;
                    wc = 3 * k;
                end else begin
                    wp = len - k;
                    wc = k;
                end
                mean     = (wp * prev_sample + wc * cur) / (wp + wc);
                pt.value = mean[SAMPLE_BITS-1:0];
                pt.phase = k[PHASE_BITS-1:0];
                pt.last  = 1'b0;
                pending_points.insert(pending_points.size(), pt);
            end
        end
        pt.value = raw;
        pt.phase = '0;
        pt.last  = 1'b1;
        pending_points.insert(pending_points.size(), pt);
        prev_sample = cur;
        have_prev   = 1'b1;
    endtask

    always @(posedge i_clk) begin
        t_point want;
        if (!i_rst_n) begin
            factor_reg  = CFG_BITS'(FACTOR_RESET);
            band_reg    = CFG_BITS'(BAND_RESET);
            prev_sample = 0;
            have_prev   = 1'b0;
            pending_points.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (pending_points.size() == 0) begin
                    o_fails++;
                    if (o_fails <= REPORT_LIMIT)
                        $display("unexpected point: value=%0d phase=%0d last=%0b",
                                 $signed(i_value), i_phase, i_last);
                end else begin
                    want = pending_points.pop_front();
                    if (want.value !== i_value || want.phase !== i_phase
                            || want.last !== i_last) begin
                        o_fails++;
                        if (o_fails <= REPORT_LIMIT)
                            $display({"mismatch: expected value=%0d phase=%0d last=%0b,",
                                      " got value=%0d phase=%0d last=%0b"},
                                     $signed(want.value), want.phase, want.last,
                                     $signed(i_value), i_phase, i_last);
                    end
                end
            end
            if (i_cfg_we) begin
                case (t_cfg_reg'(i_cfg_idx))
                    CFG_FACTOR: factor_reg = i_cfg_data;
                    CFG_BAND:   band_reg   = i_cfg_data;
                    default:    ;
                endcase
            end
            if (i_in_valid && !i_in_stall)
                predict_segment(i_sample);
        end
        o_pending = pending_points.size();
    end

endmodule

@@ bench/tb.sv @@
// top of the upsampler testbench: clock, reset, stimulus and verdict
// depends on wiu_pkg, upsample_checker and weighted_interpolation_upsampler
module tb;
    import wiu_pkg::*;

    localparam int SAMPLE_BITS   = 16;
    localparam int RANDOM_ITEMS  = 430;
    localparam int IDLE_PCT      = 34;
    // watchdog limit; one interpolated point needs far less, the rest is stall margin
    localparam int IDLE_LIMIT    = 3000;
    localparam int SETTLE_CYCLES = 40;
    // stretch of random items where neither side idles
    localparam int CALM_FROM     = 200;
    localparam int CALM_TO       = 280;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    t_cfg_reg               cfg_idx;
    logic [CFG_BITS-1:0]    cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    logic [SAMPLE_BITS-1:0] sample;
    logic                   out_valid;
    logic                   out_stall;
    logic [SAMPLE_BITS-1:0] value;
    logic [PHASE_BITS-1:0]  phase;
    logic                   last;
    logic                   calm;
    int                     fail_count;
    int                     pending_count;
    int                     idle_cycles = 0;

    weighted_interpolation_upsampler #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_sample    (sample),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_value     (value),
        .o_phase     (phase),
        .o_last      (last)
    );

    upsample_checker #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_checker (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .i_in_stall  (in_stall),
        .i_sample    (sample),
        .i_out_valid (out_valid),
        .i_out_stall (out_stall),
        .i_value     (value),
        .i_phase     (phase),
        .i_last      (last),
        .o_fails     (fail_count),
        .o_pending   (pending_count)
    );

    // 12 time unit period
    always begin
        clk = 1'b1;
        #6;
        clk = 1'b0;
        #6;
    end

    // result side stalls at random, except in the calm stretch
    always @(negedge clk) begin
        out_stall = calm ? 1'b0 : ($urandom_range(0, 99) < IDLE_PCT);
    end

    // watchdog: cycles in a row with no transaction on either channel
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // one input transaction, with random idle cycles ahead of it;
    // stall only moves at rising edges, so it is read at the falling edge
    task automatic push_sample(input logic [SAMPLE_BITS-1:0] s);
        @(negedge clk);
        if (!calm) begin
            while ($urandom_range(0, 99) < IDLE_PCT) begin
                in_valid = 1'b0;
                @(negedge clk);
            end
        end
        in_valid = 1'b1;
        sample   = s;
        while (in_stall) @(negedge clk);
        @(posedge clk);
    endtask

    // every sample yields at least one point, so an empty queue means idle;
    // a settle window then covers the back end winding down
    task automatic drain();
        @(negedge clk);
        in_valid = 1'b0;
        while (pending_count != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input int data);
        @(negedge clk);
        cfg_we   = 1'b1;
        cfg_idx  = idx;
        cfg_data = data[CFG_BITS-1:0];
        @(negedge clk);
        cfg_we   = 1'b0;
    endtask

    // registers change only with the block idle
    task automatic set_config(input int factor, input int band);
        drain();
        write_reg(CFG_FACTOR, factor);
        write_reg(CFG_BAND, band);
    endtask

    // mostly full-range values, with extremes and small values mixed in
    function automatic logic [SAMPLE_BITS-1:0] random_sample();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 3))
                0:       return {1'b0, {(SAMPLE_BITS-1){1'b1}}};
                1:       return {1'b1, {(SAMPLE_BITS-1){1'b0}}};
                2:       return '0;
                default: return '1;
            endcase
        end
        if (r < 30)
            return SAMPLE_BITS'($signed($urandom_range(0, 30)) - 15);
        return SAMPLE_BITS'($urandom);
    endfunction

    initial begin
        int r;
        int factor;
        int span;
        int band;
        int count;
        int sent;
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_idx   = CFG_FACTOR;
        cfg_data  = '0;
        in_valid  = 1'b0;
        sample    = '0;
        out_stall = 1'b0;
        calm      = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        // reset settings; the very first sample comes out alone
        push_sample(16'h7fff);
        push_sample(16'h8000);
        push_sample(16'h0000);
        push_sample(16'hffff);
        // factor zero acts as one: pure pass-through
        set_config(0, 0);
        push_sample(16'h1234);
        push_sample(16'h8001);
        // factor and band both beyond the maximum
        set_config(127, 127);
        push_sample(16'h7fff);
        push_sample(16'h8000);
        // largest factor with no edge band
        set_config(64, 0);
        push_sample(16'h7fff);
        push_sample(16'hfffd);
        // shortest segment, truncation of odd means across zero
        set_config(2, 1);
        push_sample(16'h0003);
        push_sample(16'hfffc);
        push_sample(16'h0001);
        // factor one with a band far above it
        set_config(1, 64);
        push_sample(16'h4000);
        push_sample(16'hc000);
        // lower and upper bands meet in the middle and cover every phase
        set_config(7, 4);
        push_sample(16'h8000);
        push_sample(16'h7fff);
        push_sample(16'h0000);
        // band equal to the factor: every point takes the lower-band weights
        set_config(10, 10);
        push_sample(16'hff00);
        push_sample(16'h00ff);
        set_config(9, 3);
        push_sample(16'h5555);
        push_sample(16'haaaa);

        // random phases, mostly short segments, a few long ones
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            r = $urandom_range(0, 99);
            if (r < 60)
                factor = $urandom_range(0, 8);
            else if (r < 88)
                factor = $urandom_range(9, 24);
            else if (r < 96)
                factor = $urandom_range(25, 64);
            else
                factor = $urandom_range(65, 127);
            span = (factor < 1) ? 1 : ((factor > MAX_FACTOR) ? MAX_FACTOR : factor);
            if ($urandom_range(0, 99) < 15)
                band = $urandom_range(0, 127);
            else
                band = $urandom_range(0, span);
            count = (span > 24) ? $urandom_range(2, 6) : $urandom_range(8, 30);
            set_config(factor, band);
            repeat (count) begin
                calm = (sent >= CALM_FROM && sent < CALM_TO);
                push_sample(random_sample());
                sent++;
            end
        end
        calm = 1'b0;

        // wait out every expected point plus a settle window for strays
        drain();
        if (fail_count == 0 && pending_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
